@@ hw/rtl/sgr_pkg.sv @@
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared types, constants and arithmetic helpers of the Sobel RGB gradient.
// ----------------------------------------------------------------------------
package sgr_pkg;

  // default frame limits
  localparam int SGR_MAX_WIDTH  = 1024;
  localparam int SGR_MAX_HEIGHT = 1024;
  localparam int SGR_RESET_DIM  = 1024;

  // configuration port
  localparam int SGR_CFG_W     = 11;
  localparam int SGR_CFG_IDX_W = 1;

  typedef enum logic [SGR_CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [7:0]       chan_t;
  typedef chan_t [2:0]      rgb_t;     // 0 red, 1 green, 2 blue
  typedef logic [9:0]       wsum_t;    // a + 2b + c of one channel

  // one window column, three rows
  typedef struct packed {
    rgb_t top;
    rgb_t mid;
    rgb_t bot;
  } col_t;

  // line store entry: older row above the newer one
  typedef struct packed {
    rgb_t upper;
    rgb_t lower;
  } line_t;

  // per-item control carried from the accept stage to the store stage
  typedef struct packed {
    rgb_t pix;
    logic wr_en;      // pixel belongs to the frame, update line store
    logic top_lower;  // upper row clamps onto the lower line
    logic bot_lower;  // bottom row clamps onto the lower line
    logic out_en;     // item completes a window
    logic lclamp;     // centre on the first column
    logic rclamp;     // centre on the last column
    logic fend;       // centre is the last pixel of the frame
  } sgr_ctl_t;

  // weighted column sum, a + 2b + c
  function automatic wsum_t wsum(chan_t a, chan_t b, chan_t c);
    wsum = wsum_t'(a) + {1'b0, b, 1'b0} + wsum_t'(c);
  endfunction

  // difference of two weighted sums saturated to 0..255
  function automatic chan_t sat_diff(wsum_t pos, wsum_t neg);
    logic signed [10:0] d;
    d = $signed({1'b0, pos}) - $signed({1'b0, neg});
    if (d[10]) begin
      sat_diff = 8'd0;
    end else if (d[9:8] != 2'b00) begin
      sat_diff = 8'd255;
    end else begin
      sat_diff = d[7:0];
    end
  endfunction

endpackage

@@ hw/rtl/sgr_pix_if.sv @@
// ----------------------------------------------------------------------------
// sgr_pix_if
// Pixel stream channel: valid/ready with one RGB pixel or a flush marker.
// ----------------------------------------------------------------------------
interface sgr_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       flush_item;

  modport source (output valid, red_in, green_in, blue_in, flush_item, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, flush_item, output ready);
endinterface

@@ hw/rtl/sgr_grad_if.sv @@
// ----------------------------------------------------------------------------
// sgr_grad_if
// Gradient result channel: valid/ready with saturated X and Y responses.
// ----------------------------------------------------------------------------
interface sgr_grad_if;
  logic       valid;
  logic       ready;
  logic [7:0] grad_x_red;
  logic [7:0] grad_x_green;
  logic [7:0] grad_x_blue;
  logic [7:0] grad_y_red;
  logic [7:0] grad_y_green;
  logic [7:0] grad_y_blue;
  logic       frame_end;

  modport source (
    output valid, grad_x_red, grad_x_green, grad_x_blue,
           grad_y_red, grad_y_green, grad_y_blue, frame_end,
    input  ready
  );
  modport sink (
    input  valid, grad_x_red, grad_x_green, grad_x_blue,
           grad_y_red, grad_y_green, grad_y_blue, frame_end,
    output ready
  );
endinterface

@@ hw/rtl/sgr_ram.sv @@
// ----------------------------------------------------------------------------
// sgr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/sobel_rgb_gradient_top.sv @@
// ----------------------------------------------------------------------------
// sobel_rgb_gradient_top
// 3x3 Sobel X/Y gradient of an RGB raster stream with edge clamping.
// ----------------------------------------------------------------------------
//
//  channel     dir   handshake            payload
//  ----------  ----  -------------------  --------------------------------------
//  pixels      in    valid / ready        red_in, green_in, blue_in, flush_item
//  gradients   out   valid / ready        grad_x_*, grad_y_*, frame_end
//  cfg         in    cfg_wr_en (no wait)  cfg_index, cfg_data
//
//  one pixel transaction per clock; a result passes the s1, window and output
//  registers once its window is complete (pixel p completes on item p+width+1)
//  the rate is set by the single read and single write port of the line store
//  ram, which are used once per transaction in two consecutive stages
//  reset presets size, clears counters, valid flags; line store needs no clear
//  a stalled output holds the whole pipe; pixels.ready is low only then
//
module sobel_rgb_gradient_top
  import sgr_pkg::*;
#(
  parameter int MAX_WIDTH  = SGR_MAX_WIDTH,
  parameter int MAX_HEIGHT = SGR_MAX_HEIGHT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [SGR_CFG_IDX_W-1:0] cfg_index,
  input  logic [SGR_CFG_W-1:0]     cfg_data,
  sgr_pix_if.sink                  pixels,
  sgr_grad_if.source               gradients
);

  // column address, frame dimensions and row counter widths
  localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int DIM_W   = $clog2(MAX_WIDTH + 1);
  localparam int DIM_H_W = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W   = $clog2(MAX_HEIGHT + 2);   // row runs to height+1
  localparam int LINE_W  = $bits(line_t);

  localparam logic [DIM_W-1:0]   RST_W =
    DIM_W'((SGR_RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : SGR_RESET_DIM);
  localparam logic [DIM_H_W-1:0] RST_H =
    DIM_H_W'((SGR_RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : SGR_RESET_DIM);

  // --------------------------------------------------------------------------
  // configuration, stored already clamped to 1..max
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0]   width_eff;
  logic [DIM_H_W-1:0] height_eff;
  logic [DIM_W-1:0]   cfg_w_clamped;
  logic [DIM_H_W-1:0] cfg_h_clamped;

  always_comb begin
    priority if (cfg_data == '0) begin
      cfg_w_clamped = DIM_W'(1);
    end else if (int'(cfg_data) > MAX_WIDTH) begin
      cfg_w_clamped = DIM_W'(MAX_WIDTH);
    end else begin
      cfg_w_clamped = DIM_W'(cfg_data);
    end
    priority if (cfg_data == '0) begin
      cfg_h_clamped = DIM_H_W'(1);
    end else if (int'(cfg_data) > MAX_HEIGHT) begin
      cfg_h_clamped = DIM_H_W'(MAX_HEIGHT);
    end else begin
      cfg_h_clamped = DIM_H_W'(cfg_data);
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control: every stage moves together when the output can move
  // --------------------------------------------------------------------------
  logic advance;
  logic in_acc;
  logic out_valid;

  assign advance      = !out_valid || gradients.ready;
  assign pixels.ready = advance;
  assign in_acc       = pixels.valid && advance;

  // --------------------------------------------------------------------------
  // raster position of the incoming transaction
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             col_last;
  logic             frame_last;
  logic [ROW_W-1:0] height_row;

  assign height_row = ROW_W'(height_eff);
  assign col_last   = (DIM_W'(col) == width_eff - DIM_W'(1));
  assign frame_last = (row == height_row + ROW_W'(1));   // last flush item

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= RST_W;
      height_eff <= RST_H;
      col        <= '0;
      row        <= '0;
    end else if (cfg_wr_en) begin
      // any register write restarts the frame
      unique case (cfg_reg_t'(cfg_index))
        CFG_FRAME_WIDTH:  width_eff  <= cfg_w_clamped;
        CFG_FRAME_HEIGHT: height_eff <= cfg_h_clamped;
        default:          width_eff  <= width_eff;
      endcase
      col <= '0;
      row <= '0;
    end else if (in_acc) begin
      if (frame_last) begin
        col <= '0;
        row <= '0;
      end else if (col_last) begin
        col <= '0;
        row <= row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // per-transaction control decoded from the position
  sgr_ctl_t ctl_next;

  always_comb begin
    ctl_next.pix       = pixels.flush_item ? '0
                       : {pixels.blue_in, pixels.green_in, pixels.red_in};
    ctl_next.wr_en     = (row < height_row);
    ctl_next.top_lower = (row <= ROW_W'(1));
    ctl_next.bot_lower = (row >= height_row);
    ctl_next.out_en    = (row >= ROW_W'(2)) || (row == ROW_W'(1) && col != '0);
    ctl_next.rclamp    = (col == '0);
    ctl_next.lclamp    = (col == COL_W'(1)) || (width_eff == DIM_W'(1));
    ctl_next.fend      = frame_last;
  end

  // --------------------------------------------------------------------------
  // line store: one entry per column, holding the two previous rows
  // read on accept, written back one stage later
  // --------------------------------------------------------------------------
  logic             s1_valid;
  sgr_ctl_t         s1_ctl;
  logic [COL_W-1:0] s1_addr;
  logic             s1_fwd;
  line_t            s1_fwd_data;
  line_t            ram_rdata;
  line_t            entry;
  line_t            wr_data;
  logic             ram_we;

  // with a one-pixel row the same entry is read while it is being written
  assign entry   = s1_fwd ? s1_fwd_data : ram_rdata;
  assign wr_data = '{upper: entry.lower, lower: s1_ctl.pix};
  assign ram_we  = advance && s1_valid && s1_ctl.wr_en;

  sgr_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (wr_data),
    .re    (in_acc),
    .raddr (col),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ctl      <= ctl_next;
      s1_addr     <= col;
      s1_fwd      <= ram_we && (s1_addr == col);
      s1_fwd_data <= wr_data;
    end
  end

  // new column with row clamping applied
  col_t col_new;

  always_comb begin
    col_new.top = s1_ctl.top_lower ? entry.lower : entry.upper;
    col_new.mid = entry.lower;
    col_new.bot = s1_ctl.bot_lower ? entry.lower : s1_ctl.pix;
  end

  // --------------------------------------------------------------------------
  // 3x3 window as three column registers, left to right
  // --------------------------------------------------------------------------
  col_t col_a;
  col_t col_b;
  col_t col_c;
  logic s2_valid;
  logic s2_lclamp;
  logic s2_rclamp;
  logic s2_fend;

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      col_a <= col_b;
      col_b <= col_c;
      col_c <= col_new;
    end
    if (advance) begin
      s2_lclamp <= s1_ctl.lclamp;
      s2_rclamp <= s1_ctl.rclamp;
      s2_fend   <= s1_ctl.fend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid && s1_ctl.out_en;
    end
  end

  // --------------------------------------------------------------------------
  // kernel sums with column clamping, saturated per channel
  // --------------------------------------------------------------------------
  col_t left;
  col_t right;
  rgb_t gx;
  rgb_t gy;

  always_comb begin
    left  = s2_lclamp ? col_b : col_a;
    right = s2_rclamp ? col_b : col_c;
    for (int ch = 0; ch < 3; ch++) begin
      gx[ch] = sat_diff(wsum(right.top[ch], right.mid[ch], right.bot[ch]),
                        wsum(left.top[ch],  left.mid[ch],  left.bot[ch]));
      gy[ch] = sat_diff(wsum(left.bot[ch],  col_b.bot[ch], right.bot[ch]),
                        wsum(left.top[ch],  col_b.top[ch], right.top[ch]));
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  rgb_t gx_q;
  rgb_t gy_q;
  logic fend_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gx_q   <= gx;
      gy_q   <= gy;
      fend_q <= s2_fend;
    end
  end

  assign gradients.valid        = out_valid;
  assign gradients.grad_x_red   = gx_q[0];
  assign gradients.grad_x_green = gx_q[1];
  assign gradients.grad_x_blue  = gx_q[2];
  assign gradients.grad_y_red   = gy_q[0];
  assign gradients.grad_y_green = gy_q[1];
  assign gradients.grad_y_blue  = gy_q[2];
  assign gradients.frame_end    = fend_q;

endmodule

@@ hw/rtl/sgr_checker.sv @@
// ----------------------------------------------------------------------------
// sgr_checker
// Port-level checks of the Sobel RGB gradient, bound to the top level.
// ----------------------------------------------------------------------------
module sgr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] gx_r,
  input logic [7:0] gx_g,
  input logic [7:0] gx_b,
  input logic [7:0] gy_r,
  input logic [7:0] gy_g,
  input logic [7:0] gy_b,
  input logic       frame_end
);

  // no result straight after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // input stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a blocked result");

  // a blocked result lets no new transaction in
  a_blocked_no_accept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(in_valid && in_ready))
    else $error("transaction accepted while result blocked");

  // blocked result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(gx_r) && $stable(gx_g) && $stable(gx_b) &&
       $stable(gy_r) && $stable(gy_g) && $stable(gy_b) && $stable(frame_end)))
    else $error("blocked result changed");

endmodule

bind sobel_rgb_gradient_top sgr_checker u_sgr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixels.valid),
  .in_ready  (pixels.ready),
  .out_valid (gradients.valid),
  .out_ready (gradients.ready),
  .gx_r      (gradients.grad_x_red),
  .gx_g      (gradients.grad_x_green),
  .gx_b      (gradients.grad_x_blue),
  .gy_r      (gradients.grad_y_red),
  .gy_g      (gradients.grad_y_green),
  .gy_b      (gradients.grad_y_blue),
  .frame_end (gradients.frame_end)
);

@@ sim/tb_sobel_rgb_gradient_top.sv @@
// ----------------------------------------------------------------------------
// tb_sobel_rgb_gradient_top
// Self-checking bench for the Sobel RGB gradient. An internal predictor keeps
// its own pixel history and frame counter, works out the clamped and
// saturated X/Y responses of every accepted pixel transaction and checks the
// gradient transactions against them in order, under random stalls on both
// channels and across several frame geometries, the extremes among them.
// ----------------------------------------------------------------------------
module tb_sobel_rgb_gradient_top
  import sgr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // history covers two full rows plus the window, indexed by item number
  localparam int HIST_DEPTH  = 2 * SGR_MAX_WIDTH + 4;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_OFF    = 6;   // settle time after draining, before a register write
  localparam int MAX_REPORTS = 200;

  typedef logic [SGR_CFG_W-1:0] cfg_word_t;

  // one gradient transaction, channels indexed 0 red, 1 green, 2 blue
  typedef struct packed {
    rgb_t gx;
    rgb_t gy;
    logic fend;
  } grad_t;

  // --------------------------------------------------------------------------
  // predictor and result store
  // --------------------------------------------------------------------------
  class sobel_scoreboard;
    cfg_word_t width_reg;
    cfg_word_t height_reg;
    rgb_t      recent_pixels [HIST_DEPTH];
    int        item_no;          // position within the current frame
    grad_t     pending_grads [$];
    int        grads_seen;
    int        errors;

    function new();
      width_reg  = cfg_word_t'(SGR_RESET_DIM);
      height_reg = cfg_word_t'(SGR_RESET_DIM);
      foreach (recent_pixels[i]) recent_pixels[i] = '0;
      item_no    = 0;
      grads_seen = 0;
      errors     = 0;
    endfunction

    // zero counts as one, anything beyond the maximum as the maximum
    function int cols();
      if (width_reg == 0) return 1;
      if (width_reg > SGR_MAX_WIDTH) return SGR_MAX_WIDTH;
      return int'(width_reg);
    endfunction

    function int rows();
      if (height_reg == 0) return 1;
      if (height_reg > SGR_MAX_HEIGHT) return SGR_MAX_HEIGHT;
      return int'(height_reg);
    endfunction

    function int clip(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function chan_t saturate(int s);
      if (s < 0) return 8'd0;
      if (s > 255) return 8'd255;
      return chan_t'(s);
    endfunction

    // any register write also restarts the frame
    function void write_reg(cfg_reg_t idx, cfg_word_t value);
      if (idx == CFG_FRAME_WIDTH) width_reg = value;
      else height_reg = value;
      item_no = 0;
    endfunction

    // accepted pixel transaction: store it and predict the gradient it completes
    function void take_pixel(rgb_t pix, logic flush);
      int    w, h, total, k, p;
      int    r0, c0, rr, cc, v;
      int    sum_x [3];
      int    sum_y [3];
      rgb_t  nb;
      grad_t g;
      w     = cols();
      h     = rows();
      total = w * h;
      k     = item_no;
      // a flush inside the picture counts as black
      if (k < total) recent_pixels[k % HIST_DEPTH] = flush ? rgb_t'('0) : pix;
      if (k > w) begin
        p  = k - w - 1;
        r0 = p / w;
        c0 = p % w;
        for (int ch = 0; ch < 3; ch++) begin
          sum_x[ch] = 0;
          sum_y[ch] = 0;
        end
        // separable kernels: derivative (-1 0 1) times smoothing (1 2 1)
        for (int dr = 0; dr < 3; dr++) begin
          rr = clip(r0 + dr - 1, 0, h - 1);
          for (int dc = 0; dc < 3; dc++) begin
            cc = clip(c0 + dc - 1, 0, w - 1);
            nb = recent_pixels[(rr * w + cc) % HIST_DEPTH];
            for (int ch = 0; ch < 3; ch++) begin
              v = int'(nb[ch]);
              sum_x[ch] += v * (dc - 1) * ((dr == 1) ? 2 : 1);
              sum_y[ch] += v * (dr - 1) * ((dc == 1) ? 2 : 1);
            end
          end
        end
        for (int ch = 0; ch < 3; ch++) begin
          g.gx[ch] = saturate(sum_x[ch]);
          g.gy[ch] = saturate(sum_y[ch]);
        end
        g.fend = (p == total - 1);
        pending_grads.push_back(g);
      end
      item_no = (k >= total + w) ? 0 : k + 1;
    endfunction

    task report(string msg);
      if (errors < MAX_REPORTS) $display("%0t ns  mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_gradient(grad_t got);
      grad_t want;
      string chan_name [3];
      chan_name = '{"red", "green", "blue"};
      grads_seen++;
      if (pending_grads.size() == 0) begin
        report($sformatf("gradient %0d arrived with nothing expected", grads_seen));
        return;
      end
      want = pending_grads.pop_front();
      for (int ch = 0; ch < 3; ch++) begin
        if (got.gx[ch] !== want.gx[ch])
          report($sformatf("gradient %0d grad_x_%s is %0d, expected %0d", grads_seen,
                           chan_name[ch], got.gx[ch], want.gx[ch]));
        if (got.gy[ch] !== want.gy[ch])
          report($sformatf("gradient %0d grad_y_%s is %0d, expected %0d", grads_seen,
                           chan_name[ch], got.gy[ch], want.gy[ch]));
      end
      if (got.fend !== want.fend)
        report($sformatf("gradient %0d frame_end is %b, expected %b", grads_seen,
                         got.fend, want.fend));
    endtask

    function int pending();
      return pending_grads.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic      clk;
  logic      rst;
  logic      cfg_wr_en;
  cfg_reg_t  cfg_index;
  cfg_word_t cfg_data;

  sgr_pix_if  pix_ch ();
  sgr_grad_if grad_ch ();

  sobel_scoreboard sb;
  int src_idle_pct;   // chance in a hundred that the sender holds back a cycle
  int snk_idle_pct;   // chance in a hundred that the receiver stalls a cycle
  int cycle_count = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  sobel_rgb_gradient_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pix_ch),
    .gradients (grad_ch)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    grad_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // watch both channels; values read here are the ones the block saw at this edge
  always @(posedge clk) begin : watch
    grad_t seen;
    if (!rst) begin
      if (pix_ch.valid && pix_ch.ready)
        sb.take_pixel({pix_ch.blue_in, pix_ch.green_in, pix_ch.red_in}, pix_ch.flush_item);
      if (grad_ch.valid && grad_ch.ready) begin
        seen.gx   = {grad_ch.grad_x_blue, grad_ch.grad_x_green, grad_ch.grad_x_red};
        seen.gy   = {grad_ch.grad_y_blue, grad_ch.grad_y_green, grad_ch.grad_y_red};
        seen.fend = grad_ch.frame_end;
        sb.check_gradient(seen);
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // hard stop in case the block hangs
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic rgb_t mk_rgb(chan_t r, chan_t g, chan_t b);
    return {b, g, r};
  endfunction

  // full-range colours with extra weight on black and white to hit saturation
  function automatic chan_t rand_level();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return chan_t'($urandom_range(255));
    endcase
  endfunction

  function automatic rgb_t rand_pixel();
    return {rand_level(), rand_level(), rand_level()};
  endfunction

  // one pixel transaction, with random hold-back beforehand
  task automatic send_item(input rgb_t pix, input logic flush);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid      <= 1'b1;
    pix_ch.red_in     <= pix[0];
    pix_ch.green_in   <= pix[1];
    pix_ch.blue_in    <= pix[2];
    pix_ch.flush_item <= flush;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
  endtask

  // sender stops until every predicted gradient has come back
  task automatic wait_drained();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // drained and settled, safe for a register write
  task automatic quiesce();
    wait_drained();
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input cfg_word_t value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // a whole frame: pixels then the flush tail, with some misplaced items mixed in
  task automatic run_frame(output int length);
    int picture, i;
    picture = sb.cols() * sb.rows();
    length  = picture + sb.cols() + 1;
    for (i = 0; i < length; i++) begin
      if (i < picture) send_item(rand_pixel(), $urandom_range(99) < 5);
      else send_item(rand_pixel(), $urandom_range(99) >= 12);
      if ($urandom_range(149) == 0) wait_drained();
    end
  endtask

  // opening items of a large frame, left unfinished for the next register write
  task automatic run_items(input int count);
    int picture, i;
    picture = sb.cols() * sb.rows();
    for (i = 0; i < count; i++) begin
      if (i < picture) send_item(rand_pixel(), 1'b0);
      else send_item(rand_pixel(), 1'b1);
    end
  endtask

  // small random geometries, sometimes several frames back to back
  task automatic random_frames(input int budget);
    int done, n;
    done = 0;
    while (done < budget) begin
      if (done == 0 || $urandom_range(2) == 0) begin
        quiesce();
        case ($urandom_range(2))
          0: write_reg(CFG_FRAME_WIDTH, cfg_word_t'($urandom_range(12, 1)));
          1: write_reg(CFG_FRAME_HEIGHT, cfg_word_t'($urandom_range(5, 1)));
          default: begin
            write_reg(CFG_FRAME_WIDTH, cfg_word_t'($urandom_range(12, 1)));
            write_reg(CFG_FRAME_HEIGHT, cfg_word_t'($urandom_range(5, 1)));
          end
        endcase
      end
      run_frame(n);
      done += n;
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin : main
    int settle;
    sb           = new();
    src_idle_pct = 24;
    snk_idle_pct = 52;
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_index    = CFG_FRAME_WIDTH;
    cfg_data     = '0;
    pix_ch.valid      = 1'b0;
    pix_ch.red_in     = '0;
    pix_ch.green_in   = '0;
    pix_ch.blue_in    = '0;
    pix_ch.flush_item = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // 3x3 frame abandoned after two pixels; rewriting the width restarts it
    write_reg(CFG_FRAME_WIDTH, cfg_word_t'(3));
    write_reg(CFG_FRAME_HEIGHT, cfg_word_t'(3));
    send_item(mk_rgb(8'd17, 8'd200, 8'd99), 1'b0);
    send_item(mk_rgb(8'd255, 8'd0, 8'd255), 1'b0);
    quiesce();
    write_reg(CFG_FRAME_WIDTH, cfg_word_t'(3));

    // full 3x3 frame: black/white extremes, corner and edge clamping
    send_item(mk_rgb(8'd255, 8'd255, 8'd255), 1'b0);
    send_item(mk_rgb(8'd0, 8'd0, 8'd0), 1'b0);
    send_item(mk_rgb(8'd255, 8'd0, 8'd0), 1'b0);
    send_item(mk_rgb(8'd0, 8'd255, 8'd0), 1'b0);
    // flush in the middle of the picture reads as a black pixel
    send_item(mk_rgb(8'hA5, 8'h5A, 8'hFF), 1'b1);
    send_item(mk_rgb(8'd0, 8'd0, 8'd255), 1'b0);
    send_item(mk_rgb(8'd255, 8'd255, 8'd255), 1'b0);
    send_item(mk_rgb(8'd0, 8'd0, 8'd0), 1'b0);
    send_item(mk_rgb(8'd255, 8'd255, 8'd255), 1'b0);
    // a real pixel in the flush tail only pushes results out, its colour is dropped
    send_item(mk_rgb(8'h3C, 8'hC3, 8'h81), 1'b0);
    send_item(mk_rgb(8'h00, 8'hFF, 8'h00), 1'b1);
    send_item(mk_rgb(8'hFF, 8'h00, 8'hFF), 1'b1);
    send_item(mk_rgb(8'h5A, 8'hA5, 8'h0F), 1'b1);

    // single-pixel frame: every neighbour clamps onto the pixel itself
    quiesce();
    write_reg(CFG_FRAME_WIDTH, cfg_word_t'(1));
    write_reg(CFG_FRAME_HEIGHT, cfg_word_t'(1));
    send_item(mk_rgb(8'd255, 8'd0, 8'd128), 1'b0);
    send_item(mk_rgb(8'd1, 8'd2, 8'd3), 1'b1);
    send_item(mk_rgb(8'd0, 8'd255, 8'd7), 1'b0);

    // sender light gaps, receiver heavy stalls; start of a widest-line single row
    random_frames(100);
    quiesce();
    write_reg(CFG_FRAME_WIDTH, cfg_word_t'(SGR_MAX_WIDTH));
    write_reg(CFG_FRAME_HEIGHT, cfg_word_t'(1));
    run_items(24);

    // roles swapped; width zero reads as one, oversized height as the maximum
    src_idle_pct = 52;
    snk_idle_pct = 24;
    random_frames(100);
    quiesce();
    write_reg(CFG_FRAME_WIDTH, cfg_word_t'(0));
    write_reg(CFG_FRAME_HEIGHT, '1);
    run_items(40);

    // full rate both ways; oversized width over three rows
    src_idle_pct = 0;
    snk_idle_pct = 0;
    random_frames(100);
    quiesce();
    write_reg(CFG_FRAME_WIDTH, '1);
    write_reg(CFG_FRAME_HEIGHT, cfg_word_t'(3));
    run_items(24);

    // drain with a bound, then a short window for anything unexpected
    pix_ch.valid <= 1'b0;
    settle = 0;
    while (sb.pending() != 0 && settle < 5000) begin
      @(posedge clk);
      settle++;
    end
    if (sb.pending() != 0)
      sb.report($sformatf("%0d gradients never arrived", sb.pending()));
    repeat (20) @(posedge clk);

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
